// ===== src/mml_pkg.sv =====
`default_nettype none

package mml_pkg;

  localparam int CMD_W      = 2;
  localparam int LEAF_W     = 16;
  localparam int CNT_W      = 32;
  localparam int IDX_W      = 5;
  localparam int MRU_LEN_W  = 5;
  localparam int MFU_LEN_W  = 6;
  localparam int MRU_SIZE_W = 5;
  localparam int MFU_SIZE_W = 6;

  localparam int MRU_DEPTH_DEF = 16;
  localparam int MFU_DEPTH_DEF = 32;
  localparam int ID_WIDTH_DEF  = 16;

  localparam logic [MRU_SIZE_W-1:0] MRU_SIZE_RST = MRU_SIZE_W'(10);
  localparam logic [MFU_SIZE_W-1:0] MFU_SIZE_RST = MFU_SIZE_W'(30);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_MRU_SIZE = 1'b0;
  localparam logic REG_MFU_SIZE = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [LEAF_W-1:0] leaf_id;
    logic [CNT_W-1:0]  use_count;
    logic [IDX_W-1:0]  index;
  } item_t;

  typedef struct packed {
    logic                 was_in_mru;
    logic                 was_in_mfu;
    logic                 mru_evicted_valid;
    logic [LEAF_W-1:0]    mru_evicted_id;
    logic                 mfu_evicted_valid;
    logic [LEAF_W-1:0]    mfu_evicted_id;
    logic [MRU_LEN_W-1:0] mru_length;
    logic [MFU_LEN_W-1:0] mfu_length;
    logic [LEAF_W-1:0]    read_mru_id;
    logic [LEAF_W-1:0]    read_mfu_id;
    logic [CNT_W-1:0]     read_mfu_count;
  } result_t;

  typedef struct packed {
    logic [MRU_SIZE_W-1:0] rec_size;
    logic [MFU_SIZE_W-1:0] frq_size;
  } cfg_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== src/mml_if.sv =====
`default_nettype none

interface mml_item_if;
  import mml_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mml_result_if;
  import mml_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/mml_store.sv =====
`default_nettype none

module mml_store #(
  parameter int DEPTH = 16,
  parameter int DW    = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [mml_pkg::addr_w(DEPTH)-1:0]      waddr_i,
  input  wire logic [DW-1:0]                          wdata_i,
  input  wire logic [mml_pkg::addr_w(DEPTH)-1:0]      raddr_i,
  output logic      [DW-1:0]                          rdata_o
);
  import mml_pkg::*;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/mml_cfg.sv =====
`default_nettype none

module mml_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mml_pkg::APB_AW-1:0]     paddr,
  input  wire logic [mml_pkg::APB_DW-1:0]     pwdata,
  output logic      [mml_pkg::APB_DW-1:0]     prdata,
  output logic                                pready,
  output mml_pkg::cfg_t                       cfg_o
);
  import mml_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_MRU_SIZE: cfg_d.rec_size = pwdata[MRU_SIZE_W-1:0];
        REG_MFU_SIZE: cfg_d.frq_size = pwdata[MFU_SIZE_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MRU_SIZE: prdata = APB_DW'(cfg_q.rec_size);
      REG_MFU_SIZE: prdata = APB_DW'(cfg_q.frq_size);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rec_size <= MRU_SIZE_RST;
      cfg_q.frq_size <= MFU_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/mru_mfu_list_manager.sv =====
`default_nettype none

// Recency / frequency list manager. Keeps a move-to-front recency list and a
// frequency list sorted by descending use count, both held in memories with
// one read and one write port, and updated by a sequencer that walks them one
// entry per cycle. One item is in flight at a time; in_i.ready is high only
// while the sequencer is idle. A touch or remove first sweeps both lists up
// to the longer of their lengths Lr/Lf (search sweep), then shifts Sr
// entries of the recency list and then Sf of the frequency list (one memory
// read and write per entry); a touch then writes the item into its new
// places. Clear sets both lengths to zero and read looks up one index in
// both lists. The result sits in an output register, so a new item may start
// while it waits; a finished item holds until that register is free.
// List sizes are set through the APB port at 0x0 (recency, reset 10) and 0x4
// (frequency, reset 30); zero acts as 1, values above the depth as the depth.
module mru_mfu_list_manager #(
  parameter int MRU_DEPTH = mml_pkg::MRU_DEPTH_DEF,
  parameter int MFU_DEPTH = mml_pkg::MFU_DEPTH_DEF,
  parameter int ID_WIDTH  = mml_pkg::ID_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  mml_item_if.sink                        in_i,
  mml_result_if.source                    out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mml_pkg::APB_AW-1:0] paddr,
  input  wire logic [mml_pkg::APB_DW-1:0] pwdata,
  output logic      [mml_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import mml_pkg::*;

  localparam int RAW = addr_w(MRU_DEPTH);
  localparam int FAW = addr_w(MFU_DEPTH);
  localparam int RLW = $clog2(MRU_DEPTH + 1);
  localparam int FLW = $clog2(MFU_DEPTH + 1);
  localparam int SW  = (RLW > FLW) ? RLW : FLW;
  localparam int FDW = ID_WIDTH + CNT_W;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_RMOVE = 8'b0000_0100,
    ST_FMOVE = 8'b0000_1000,
    ST_PUT   = 8'b0001_0000,
    ST_READ  = 8'b0010_0000,
    ST_RDATA = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  cfg_t cfg;

  mml_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // memory ports
  logic                r_we, f_we;
  logic [RAW-1:0]      r_waddr, r_raddr;
  logic [FAW-1:0]      f_waddr, f_raddr;
  logic [ID_WIDTH-1:0] r_wdata, r_rdata;
  logic [FDW-1:0]      f_wdata, f_rdata;
  logic [ID_WIDTH-1:0] f_id;
  logic [CNT_W-1:0]    f_cnt;

  mml_store #(.DEPTH(MRU_DEPTH), .DW(ID_WIDTH)) u_rec (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  mml_store #(.DEPTH(MFU_DEPTH), .DW(FDW)) u_frq (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  assign f_id  = f_rdata[CNT_W +: ID_WIDTH];
  assign f_cnt = f_rdata[CNT_W-1:0];

  // control state
  state_e         state_q, state_d;
  logic [RLW-1:0] rlen_q, rlen_d;
  logic [FLW-1:0] flen_q, flen_d;
  logic           pv_q, pv_d;
  logic           mv_pend_q, mv_pend_d;
  logic           out_valid_q, out_valid_d;

  // item and working registers
  cmd_e                cmd_q, cmd_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SW-1:0]       sc_q, sc_d, pidx_q, pidx_d;
  logic                rfound_q, rfound_d, ffound_q, ffound_d;
  logic [SW-1:0]       rpos_q, rpos_d, fpos_q, fpos_d;
  logic [ID_WIDTH-1:0] rtail_q, rtail_d, ftail_id_q, ftail_id_d;
  logic [CNT_W-1:0]    ftail_cnt_q, ftail_cnt_d;
  logic [FLW-1:0]      call_q, call_d, ccut_q, ccut_d;
  logic [SW-1:0]       mv_cur_q, mv_cur_d, mv_rem_q, mv_rem_d, mv_dst_q, mv_dst_d;
  logic                mv_right_q, mv_right_d;
  logic [SW-1:0]       fmv_start_q, fmv_start_d, fmv_cnt_q, fmv_cnt_d;
  logic                fmv_right_q, fmv_right_d;
  logic                rput_q, rput_d, fput_q, fput_d;
  logic [SW-1:0]       fput_pos_q, fput_pos_d;
  result_t             stg_q, stg_d, out_q, out_d;

  // effective sizes
  logic [RLW-1:0] rlim;
  logic [FLW-1:0] flim;
  logic [SW-1:0]  rlim_m1, flim_m1, scan_n;

  assign rlim = (cfg.rec_size == '0) ? RLW'(1) :
                (int'(cfg.rec_size) > MRU_DEPTH) ? RLW'(MRU_DEPTH) : RLW'(cfg.rec_size);
  assign flim = (cfg.frq_size == '0) ? FLW'(1) :
                (int'(cfg.frq_size) > MFU_DEPTH) ? FLW'(MFU_DEPTH) : FLW'(cfg.frq_size);
  assign rlim_m1 = SW'(rlim) - SW'(1);
  assign flim_m1 = SW'(flim) - SW'(1);
  assign scan_n  = (SW'(rlen_q) > SW'(flen_q)) ? SW'(rlen_q) : SW'(flen_q);

  // recency plan for a touch: entries 0..rec_e-1 move down by one
  logic [SW-1:0]  rec_e;
  logic           rec_ev;
  logic [RLW-1:0] rlen_nx;

  always_comb begin
    rec_ev  = 1'b0;
    rec_e   = SW'(rlen_q);
    rlen_nx = rlen_q + RLW'(1);
    if (rfound_q) begin
      rec_e   = rpos_q;
      rlen_nx = rlen_q;
    end else if (rlen_q >= rlim) begin
      rec_ev  = 1'b1;
      rec_e   = rlim_m1;
      rlen_nx = rlim;
    end
  end

  // frequency plan for a touch
  logic           frq_ev, frq_put, frq_right;
  logic [SW-1:0]  frq_pos, frq_start, frq_cnt;
  logic [FLW-1:0] flen_nx;

  always_comb begin
    frq_ev    = 1'b0;
    frq_put   = 1'b1;
    frq_right = 1'b1;
    frq_pos   = SW'(call_q);
    flen_nx   = flen_q;
    frq_start = SW'(flen_q) - SW'(1);
    frq_cnt   = SW'(flen_q) - SW'(call_q);
    if (ffound_q) begin
      if (SW'(call_q) <= fpos_q) begin
        frq_start = fpos_q - SW'(1);
        frq_cnt   = fpos_q - SW'(call_q);
      end else begin
        frq_right = 1'b0;
        frq_start = fpos_q + SW'(1);
        frq_cnt   = SW'(call_q) - fpos_q;
      end
    end else if (flen_q < flim) begin
      flen_nx = flen_q + FLW'(1);
    end else if (cnt_q > ftail_cnt_q) begin
      // new count beats the tail: drop it and insert among the first size-1
      frq_ev    = 1'b1;
      frq_pos   = SW'(ccut_q);
      frq_start = flim_m1 - SW'(1);
      frq_cnt   = flim_m1 - SW'(ccut_q);
      flen_nx   = flim;
    end else begin
      frq_put = 1'b0;
      frq_cnt = '0;
    end
  end

  logic mv_done;
  assign mv_done = (mv_rem_q == '0) && !mv_pend_q;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    rlen_d      = rlen_q;
    flen_d      = flen_q;
    pv_d        = pv_q;
    mv_pend_d   = mv_pend_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    sc_d        = sc_q;
    pidx_d      = pidx_q;
    rfound_d    = rfound_q;
    ffound_d    = ffound_q;
    rpos_d      = rpos_q;
    fpos_d      = fpos_q;
    rtail_d     = rtail_q;
    ftail_id_d  = ftail_id_q;
    ftail_cnt_d = ftail_cnt_q;
    call_d      = call_q;
    ccut_d      = ccut_q;
    mv_cur_d    = mv_cur_q;
    mv_rem_d    = mv_rem_q;
    mv_dst_d    = mv_dst_q;
    mv_right_d  = mv_right_q;
    fmv_start_d = fmv_start_q;
    fmv_cnt_d   = fmv_cnt_q;
    fmv_right_d = fmv_right_q;
    rput_d      = rput_q;
    fput_d      = fput_q;
    fput_pos_d  = fput_pos_q;
    stg_d       = stg_q;
    out_d       = out_q;

    r_we    = 1'b0;
    r_waddr = '0;
    r_wdata = r_rdata;
    r_raddr = '0;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = f_rdata;
    f_raddr = '0;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // shared mover: one entry read per cycle, written one slot over next cycle
    if ((state_q == ST_RMOVE) || (state_q == ST_FMOVE)) begin
      if (mv_rem_q != '0) begin
        mv_cur_d  = mv_right_q ? (mv_cur_q - SW'(1)) : (mv_cur_q + SW'(1));
        mv_dst_d  = mv_right_q ? (mv_cur_q + SW'(1)) : (mv_cur_q - SW'(1));
        mv_rem_d  = mv_rem_q - SW'(1);
        mv_pend_d = 1'b1;
      end else begin
        mv_pend_d = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          cmd_d = in_i.data.cmd;
          id_d  = ID_WIDTH'(in_i.data.leaf_id);
          cnt_d = in_i.data.use_count;
          idx_d = in_i.data.index;
          stg_d = '0;
          unique case (in_i.data.cmd)
            CMD_TOUCH, CMD_REMOVE: begin
              sc_d     = '0;
              pv_d     = 1'b0;
              rfound_d = 1'b0;
              ffound_d = 1'b0;
              call_d   = '0;
              ccut_d   = '0;
              state_d  = ST_SCAN;
            end
            CMD_CLEAR: begin
              rlen_d  = '0;
              flen_d  = '0;
              state_d = ST_OUT;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_SCAN: begin
        if (sc_q < scan_n) begin
          r_raddr = RAW'(sc_q);
          f_raddr = FAW'(sc_q);
          sc_d    = sc_q + SW'(1);
          pv_d    = 1'b1;
          pidx_d  = sc_q;
        end else begin
          pv_d = 1'b0;
        end

        if (pv_q) begin
          if (pidx_q < SW'(rlen_q)) begin
            if (r_rdata == id_q) begin
              rfound_d = 1'b1;
              rpos_d   = pidx_q;
            end
            if (pidx_q == rlim_m1) begin
              rtail_d = r_rdata;
            end
          end
          if (pidx_q < SW'(flen_q)) begin
            if (f_id == id_q) begin
              ffound_d = 1'b1;
              fpos_d   = pidx_q;
            end
            // ids are unique, so this leaves out only the touched entry
            if ((f_cnt > cnt_q) && (f_id != id_q)) begin
              call_d = call_q + FLW'(1);
              if (pidx_q < flim_m1) begin
                ccut_d = ccut_q + FLW'(1);
              end
            end
            if (pidx_q == flim_m1) begin
              ftail_id_d  = f_id;
              ftail_cnt_d = f_cnt;
            end
          end
        end

        if ((sc_q == scan_n) && !pv_q) begin
          stg_d.was_in_mru = rfound_q;
          stg_d.was_in_mfu = ffound_q;
          mv_pend_d        = 1'b0;
          if (cmd_q == CMD_TOUCH) begin
            stg_d.mru_evicted_valid = rec_ev;
            stg_d.mru_evicted_id    = rec_ev ? LEAF_W'(rtail_q) : '0;
            rlen_d      = rlen_nx;
            mv_cur_d    = rec_e - SW'(1);
            mv_rem_d    = rec_e;
            mv_right_d  = 1'b1;
            rput_d      = 1'b1;
            stg_d.mfu_evicted_valid = frq_ev;
            stg_d.mfu_evicted_id    = frq_ev ? LEAF_W'(ftail_id_q) : '0;
            flen_d      = flen_nx;
            fmv_start_d = frq_start;
            fmv_cnt_d   = frq_cnt;
            fmv_right_d = frq_right;
            fput_d      = frq_put;
            fput_pos_d  = frq_pos;
          end else begin
            rput_d      = 1'b0;
            fput_d      = 1'b0;
            mv_right_d  = 1'b0;
            fmv_right_d = 1'b0;
            mv_cur_d    = rpos_q + SW'(1);
            fmv_start_d = fpos_q + SW'(1);
            mv_rem_d    = '0;
            fmv_cnt_d   = '0;
            if (rfound_q) begin
              mv_rem_d = SW'(rlen_q) - rpos_q - SW'(1);
              rlen_d   = rlen_q - RLW'(1);
            end
            if (ffound_q) begin
              fmv_cnt_d = SW'(flen_q) - fpos_q - SW'(1);
              flen_d    = flen_q - FLW'(1);
            end
          end
          state_d = ST_RMOVE;
        end
      end

      ST_RMOVE: begin
        r_raddr = RAW'(mv_cur_q);
        r_we    = mv_pend_q;
        r_waddr = RAW'(mv_dst_q);
        r_wdata = r_rdata;
        if (mv_done) begin
          mv_cur_d   = fmv_start_q;
          mv_rem_d   = fmv_cnt_q;
          mv_right_d = fmv_right_q;
          mv_pend_d  = 1'b0;
          state_d    = ST_FMOVE;
        end
      end

      ST_FMOVE: begin
        f_raddr = FAW'(mv_cur_q);
        f_we    = mv_pend_q;
        f_waddr = FAW'(mv_dst_q);
        f_wdata = f_rdata;
        if (mv_done) begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        r_we    = rput_q;
        r_waddr = '0;
        r_wdata = id_q;
        f_we    = fput_q;
        f_waddr = FAW'(fput_pos_q);
        f_wdata = {id_q, cnt_q};
        state_d = ST_OUT;
      end

      ST_READ: begin
        r_raddr = RAW'(idx_q);
        f_raddr = FAW'(idx_q);
        state_d = ST_RDATA;
      end

      ST_RDATA: begin
        if (int'(idx_q) < int'(rlen_q)) begin
          stg_d.read_mru_id = LEAF_W'(r_rdata);
        end
        if (int'(idx_q) < int'(flen_q)) begin
          stg_d.read_mfu_id    = LEAF_W'(f_id);
          stg_d.read_mfu_count = f_cnt;
        end
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d            = stg_q;
          out_d.mru_length = MRU_LEN_W'(rlen_q);
          out_d.mfu_length = MFU_LEN_W'(flen_q);
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rlen_q      <= '0;
      flen_q      <= '0;
      pv_q        <= 1'b0;
      mv_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rlen_q      <= rlen_d;
      flen_q      <= flen_d;
      pv_q        <= pv_d;
      mv_pend_q   <= mv_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    id_q        <= id_d;
    cnt_q       <= cnt_d;
    idx_q       <= idx_d;
    sc_q        <= sc_d;
    pidx_q      <= pidx_d;
    rfound_q    <= rfound_d;
    ffound_q    <= ffound_d;
    rpos_q      <= rpos_d;
    fpos_q      <= fpos_d;
    rtail_q     <= rtail_d;
    ftail_id_q  <= ftail_id_d;
    ftail_cnt_q <= ftail_cnt_d;
    call_q      <= call_d;
    ccut_q      <= ccut_d;
    mv_cur_q    <= mv_cur_d;
    mv_rem_q    <= mv_rem_d;
    mv_dst_q    <= mv_dst_d;
    mv_right_q  <= mv_right_d;
    fmv_start_q <= fmv_start_d;
    fmv_cnt_q   <= fmv_cnt_d;
    fmv_right_q <= fmv_right_d;
    rput_q      <= rput_d;
    fput_q      <= fput_d;
    fput_pos_q  <= fput_pos_d;
    stg_q       <= stg_d;
    out_q       <= out_d;
  end

endmodule

`default_nettype wire
